### hw/rtl/spq_pkg.sv
// shared types and constants of the stable priority queue
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY       = 16;
  localparam int unsigned VALUE_WIDTH    = 32;
  localparam int unsigned PRIORITY_WIDTH = 16;
  localparam int unsigned COUNT_WIDTH    = $clog2(CAPACITY + 1);
  localparam int unsigned KIND_WIDTH     = 2;
  localparam int unsigned STATUS_WIDTH   = 2;

  localparam int unsigned IN_BITS        = VALUE_WIDTH + PRIORITY_WIDTH;
  localparam int unsigned IN_DATA_WIDTH  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS       = VALUE_WIDTH + PRIORITY_WIDTH + COUNT_WIDTH + 2;
  localparam int unsigned OUT_DATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [KIND_WIDTH-1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_STATUS  = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                      valid;
    logic [VALUE_WIDTH-1:0]    value;
    logic [PRIORITY_WIDTH-1:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic                      enq;
    logic                      deq;
    logic [VALUE_WIDTH-1:0]    value;
    logic [PRIORITY_WIDTH-1:0] prio;
  } spq_op_t;

  typedef struct packed {
    logic [STATUS_WIDTH-1:0]   status;
    logic                      is_full;
    logic                      empty_flag;
    logic [COUNT_WIDTH-1:0]    entry_count;
    logic [PRIORITY_WIDTH-1:0] front_priority;
    logic [VALUE_WIDTH-1:0]    front_value;
  } spq_result_t;

endpackage

`default_nettype wire

### hw/rtl/spq_cell.sv
// one slot of the sorted cell chain
`default_nettype none

module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_op_t    op_i,
  input  spq_pkg::spq_entry_t left_i,
  input  logic                left_keep_i,
  input  spq_pkg::spq_entry_t right_i,
  output spq_pkg::spq_entry_t entry_o,
  output spq_pkg::spq_entry_t next_o,
  output logic                keep_o
);
  import spq_pkg::*;

  spq_entry_t                entry_q, entry_d;
  logic                      valid_q;
  logic [VALUE_WIDTH-1:0]    value_q;
  logic [PRIORITY_WIDTH-1:0] prio_q;

  assign entry_q = '{valid: valid_q, value: value_q, prio: prio_q};

  assign keep_o = entry_q.valid && (entry_q.prio <= op_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (op_i.enq) begin
      if (keep_o) begin
        entry_d = entry_q;
      end else if (left_keep_i) begin
        entry_d.valid = 1'b1;
        entry_d.value = op_i.value;
        entry_d.prio  = op_i.prio;
      end else begin
        entry_d = left_i;
      end
    end else if (op_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= entry_d.value;
    prio_q  <= entry_d.prio;
  end

  assign entry_o = entry_q;
  assign next_o  = entry_d;

endmodule

`default_nettype wire

### hw/rtl/spq_out_buf.sv
// two-deep result buffer between the cell chain and the output stream
`default_nettype none

module spq_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  spq_pkg::spq_result_t data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output spq_pkg::spq_result_t data_o,
  input  logic                 pop_ready_i
);
  import spq_pkg::*;

  logic        main_valid_q, main_valid_d;
  logic        skid_valid_q, skid_valid_d;
  spq_result_t main_q, main_d;
  spq_result_t skid_q, skid_d;
  logic        pop;

  assign ready_o = !skid_valid_q;
  assign pop     = main_valid_q && pop_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = push_i;
        skid_d       = data_i;
      end else begin
        main_valid_d = push_i;
        main_d       = data_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_d = 1'b1;
        skid_d       = data_i;
      end else begin
        main_valid_d = 1'b1;
        main_d       = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign valid_o = main_valid_q;
  assign data_o  = main_q;

endmodule

`default_nettype wire

### hw/rtl/stable_priority_queue_core.sv
// top level of the stable min-first priority queue built as a sorted cell chain
//
//   channel  dir  tdata                              tuser
//   s_*      in   value, priority                    kind
//   m_*      out  front value, front priority,
//                 count, empty, full                 status
//
// one beat is taken per cycle while the result buffer has room; every cell
// decides in the same cycle whether to hold, load the new entry or shift,
// and its result is registered in the result buffer before it appears on m_*.
// reset empties the chain at once; slot contents are not cleared.
// a stalled output fills the two-entry result buffer, then s_tready_o drops.
`default_nettype none

module stable_priority_queue_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  input  logic [spq_pkg::IN_DATA_WIDTH-1:0]  s_tdata_i,  // item_value, item_priority
  input  logic [spq_pkg::KIND_WIDTH-1:0]     s_tuser_i,  // kind
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [spq_pkg::OUT_DATA_WIDTH-1:0] m_tdata_o,  // front_value, front_priority,
                                                         // entry_count, empty_flag, is_full
  output logic [spq_pkg::STATUS_WIDTH-1:0]   m_tuser_o   // status
);
  import spq_pkg::*;

  spq_entry_t cell_entry [CAPACITY];
  spq_entry_t cell_next  [CAPACITY];
  logic       cell_keep  [CAPACITY];

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic        accept;
  logic        full, empty;
  spq_op_t     op;
  spq_result_t result;
  logic [STATUS_WIDTH-1:0] status;
  logic        buf_ready;
  spq_result_t buf_data;

  assign s_tready_o = buf_ready;
  assign accept     = s_tvalid_i && buf_ready;
  assign full       = (count_q == COUNT_WIDTH'(CAPACITY));
  assign empty      = (count_q == '0);

  always_comb begin
    op.enq   = 1'b0;
    op.deq   = 1'b0;
    op.value = s_tdata_i[VALUE_WIDTH-1:0];
    op.prio  = s_tdata_i[VALUE_WIDTH +: PRIORITY_WIDTH];
    status   = ST_OK;
    count_d  = count_q;
    unique case (s_tuser_i)
      KIND_ENQUEUE: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op.enq  = accept;
          count_d = accept ? count_q + COUNT_WIDTH'(1) : count_q;
        end
      end
      KIND_DEQUEUE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          op.deq  = accept;
          count_d = accept ? count_q - COUNT_WIDTH'(1) : count_q;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left_entry;
    spq_entry_t right_entry;
    logic       left_keep;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .left_i      (left_entry),
      .left_keep_i (left_keep),
      .right_i     (right_entry),
      .entry_o     (cell_entry[i]),
      .next_o      (cell_next[i]),
      .keep_o      (cell_keep[i])
    );
  end

  always_comb begin
    result.front_value    = cell_next[0].valid ? cell_next[0].value : '0;
    result.front_priority = cell_next[0].valid ? cell_next[0].prio : '0;
    result.entry_count    = count_d;
    result.empty_flag     = (count_d == '0);
    result.is_full        = (count_d == COUNT_WIDTH'(CAPACITY));
    result.status         = status;
  end

  spq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .ready_o     (buf_ready),
    .valid_o     (m_tvalid_o),
    .data_o      (buf_data),
    .pop_ready_i (m_tready_i)
  );

  assign m_tdata_o = OUT_DATA_WIDTH'({buf_data.is_full, buf_data.empty_flag, buf_data.entry_count,
                                      buf_data.front_priority, buf_data.front_value});
  assign m_tuser_o = buf_data.status;

endmodule

`default_nettype wire
